>>> rtl/mrrm_pkg.sv
// Package with shared types and constants of the Modbus RTU read-registers master.
package mrrm_pkg;

  localparam int MaxRegs = 32;
  localparam int IdxW    = $clog2(MaxRegs);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } in_kind_e;

  typedef enum logic [1:0] {
    OK_TX     = 2'd0,
    OK_REG    = 2'd1,
    OK_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_CRC    = 3'd2,
    ST_HEADER = 3'd3,
    ST_BADREQ = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_TURNAROUND = 1'b0,
    CFG_BAUD       = 1'b1
  } cfg_idx_e;

  // Input item as carried through the front queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [15:0] start_reg;
    logic [7:0]  reg_count;
    logic [7:0]  rx_byte;
  } in_item_t;

  // One CRC-16/Modbus byte update.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/mrrm_ram.sv
// Generic single-port-write, registered-read RAM.
module mrrm_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/mrrm_front.sv
// Front part: two-entry queue of input items that drops kinds with no effect.
module mrrm_front import mrrm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output in_item_t q_item_o
);
  in_item_t    buf_q [2];
  logic        rd_q, wr_q;
  logic [1:0]  cnt_q;
  logic        push, pop, keep;

  assign in_ready_o = (cnt_q != 2'd2);
  assign keep       = (in_item_i.kind != KIND_NONE);
  assign push       = in_valid_i && in_ready_o && keep;
  assign pop        = q_valid_o && q_ready_i;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("front queue overfilled");
  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
endmodule

>>> rtl/mrrm_div.sv
// Restoring divider computing the reply wire time in milliseconds, one bit a cycle.
module mrrm_div import mrrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] num_i,
  input  logic [19:0] den_i,
  output logic        busy_o,
  output logic [19:0] quo_o
);
  logic [19:0] rem_q, den_q, quo_q;
  logic [4:0]  step_q;
  logic        busy_q;
  logic [20:0] trial;

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign trial  = {rem_q, quo_q[19]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 5'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= 5'd0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'd19) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[20]) begin
        rem_q <= trial[19:0];
        quo_q <= {quo_q[18:0], 1'b1};
      end else begin
        rem_q <= {rem_q[18:0], quo_q[19]};
        quo_q <= {quo_q[18:0], 1'b0};
      end
    end
  end
endmodule

>>> rtl/mrrm_back.sv
// Back part: sequencer that runs the transaction and emits result items.
module mrrm_back import mrrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] turnaround_i,
  input  logic [19:0] baud_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  in_item_t    q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [6:0]  reg_index_o,
  output logic [15:0] reg_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_SEND, S_DIV, S_REGRD, S_REGOUT, S_STATUS
  } seq_e;

  seq_e        st_q, st_d;
  logic        wait_q, wait_d;
  logic [7:0]  slave_q, func_q;
  logic [6:0]  count_q;
  logic [15:0] addr_q;
  logic [7:0]  seen_q;
  logic [15:0] crc_q, rcrc_q;
  logic        hdr_q;
  logic [7:0]  hold_q;
  logic [31:0] dl_q;
  logic [2:0]  bi_q;
  logic [6:0]  ri_q;
  logic [2:0]  stat_q;
  logic [7:0]  frame [8];
  logic        ov_q;
  logic [1:0]  ok_q;
  logic [7:0]  otx_q;
  logic [6:0]  oidx_q;
  logic [15:0] oval_q;
  logic [2:0]  ost_q;
  logic        olast_q;
  logic        slot_free;
  logic        oload;
  logic        div_start, div_busy;
  logic [19:0] div_quo, den;
  logic [19:0] want_ms;
  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  logic [15:0] rdata;
  logic [7:0]  b, pos, want, nseen;
  logic [15:0] ncrc;
  logic [7:0]  off;

  assign slot_free = !ov_q || out_ready_i;
  assign oload     = slot_free && (st_q inside {S_SEND, S_REGOUT, S_STATUS});
  assign den       = (baud_i == 20'd0) ? 20'd9600 : baud_i;
  assign want      = 8'd5 + {count_q, 1'b0};
  assign want_ms   = {12'd0, want} * 20'd10000;
  assign b         = q_item_i.rx_byte;
  assign pos       = seen_q;
  assign off       = pos - 8'd3;
  assign ncrc      = crc_byte(rcrc_q, b);
  assign nseen     = pos + 8'd1;

  assign frame[0] = slave_q;
  assign frame[1] = func_q;
  assign frame[2] = addr_q[15:8];
  assign frame[3] = addr_q[7:0];
  assign frame[4] = 8'h00;
  assign frame[5] = {1'b0, count_q};
  assign frame[6] = crc_q[7:0];
  assign frame[7] = crc_q[15:8];

  // Register data of the reply, between the byte count and the CRC.
  assign we    = (st_q == S_IDLE) && q_valid_i && wait_q && (q_item_i.kind == KIND_BYTE)
                 && pos >= 8'd3 && pos < want - 8'd2 && off[0];
  assign waddr = off[IdxW:1];
  assign raddr = ri_q[IdxW-1:0];

  mrrm_ram #(.Width(16), .Depth(MaxRegs)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({hold_q, b}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign div_start = (st_q == S_SEND) && slot_free && (bi_q == 3'd7);

  mrrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (want_ms),
    .den_i  (den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // Next state and queue acceptance.
  always_comb begin
    st_d      = st_q;
    wait_d    = wait_q;
    q_ready_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.kind)
            KIND_START: begin
              q_ready_o = 1'b1;
              wait_d    = 1'b0;
              if (q_item_i.reg_count == 8'd0 || q_item_i.reg_count > 8'(MaxRegs)) begin
                st_d = S_STATUS;
              end else begin
                st_d = S_CRC;
              end
            end
            KIND_BYTE: begin
              q_ready_o = 1'b1;
              if (wait_q && nseen == want) begin
                wait_d = 1'b0;
                st_d   = (ncrc == 16'd0 && hdr_q) ? S_REGRD : S_STATUS;
              end
            end
            KIND_TICK: begin
              q_ready_o = 1'b1;
              if (wait_q && dl_q <= 32'd1) begin
                wait_d = 1'b0;
                st_d   = S_STATUS;
              end
            end
            default: q_ready_o = 1'b1;
          endcase
        end
      end
      S_CRC:  if (bi_q == 3'd5) st_d = S_SEND;
      S_SEND: if (slot_free && bi_q == 3'd7) st_d = S_DIV;
      S_DIV:  if (!div_busy) begin
        st_d   = S_IDLE;
        wait_d = 1'b1;
      end
      S_REGRD:  st_d = S_REGOUT;
      S_REGOUT: if (slot_free) st_d = (ri_q + 7'd1 == count_q) ? S_STATUS : S_REGRD;
      S_STATUS: if (slot_free) st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      wait_q <= 1'b0;
      ov_q   <= 1'b0;
      hdr_q  <= 1'b1;
      seen_q <= 8'd0;
      dl_q   <= 32'd0;
      count_q <= 7'd0;
      slave_q <= 8'd0;
      func_q  <= 8'd0;
      rcrc_q  <= 16'hFFFF;
      hold_q  <= 8'd0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
      // The output register fills on a load and empties when the item is taken.
      ov_q   <= oload || (ov_q && !out_ready_i);
      case (st_q)
        S_IDLE: if (q_valid_i) begin
          case (q_item_i.kind)
            KIND_START: begin
              slave_q <= q_item_i.slave_addr;
              func_q  <= q_item_i.func_code;
              addr_q  <= q_item_i.start_reg;
              count_q <= q_item_i.reg_count[6:0];
              crc_q   <= 16'hFFFF;
              bi_q    <= 3'd0;
              stat_q  <= ST_BADREQ;
              seen_q  <= 8'd0;
              rcrc_q  <= 16'hFFFF;
              hdr_q   <= 1'b1;
              hold_q  <= 8'd0;
            end
            KIND_BYTE: if (wait_q) begin
              rcrc_q <= ncrc;
              seen_q <= nseen;
              if ((pos == 8'd0 && b != slave_q) || (pos == 8'd1 && b != func_q) ||
                  (pos == 8'd2 && b != {count_q, 1'b0})) hdr_q <= 1'b0;
              if (pos >= 8'd3 && pos < want - 8'd2 && !off[0]) hold_q <= b;
              ri_q   <= 7'd0;
              stat_q <= (ncrc != 16'd0) ? ST_CRC : (!hdr_q ? ST_HEADER : ST_OK);
            end
            KIND_TICK: if (wait_q) begin
              if (dl_q != 32'd0) dl_q <= dl_q - 32'd1;
              stat_q <= ST_SHORT;
            end
            default: ;
          endcase
        end
        S_CRC: begin
          crc_q <= crc_byte(crc_q, frame[bi_q]);
          bi_q  <= (bi_q == 3'd5) ? 3'd0 : bi_q + 3'd1;
        end
        S_SEND: if (slot_free) begin
          ok_q    <= OK_TX;
          otx_q   <= frame[bi_q];
          oidx_q  <= 7'd0;
          oval_q  <= 16'd0;
          ost_q   <= ST_OK;
          olast_q <= (bi_q == 3'd7);
          bi_q    <= bi_q + 3'd1;
        end
        S_DIV: if (!div_busy) dl_q <= {16'd0, turnaround_i} + {12'd0, div_quo};
        S_REGOUT: if (slot_free) begin
          ok_q    <= OK_REG;
          otx_q   <= 8'd0;
          oidx_q  <= ri_q;
          oval_q  <= rdata;
          ost_q   <= ST_OK;
          olast_q <= 1'b0;
          ri_q    <= ri_q + 7'd1;
        end
        S_STATUS: if (slot_free) begin
          ok_q    <= OK_STATUS;
          otx_q   <= 8'd0;
          oidx_q  <= 7'd0;
          oval_q  <= 16'd0;
          ost_q   <= stat_q;
          olast_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_kind_o  = ok_q;
  assign tx_byte_o   = otx_q;
  assign reg_index_o = oidx_q;
  assign reg_value_o = oval_q;
  assign status_o    = ost_q;
  assign last_o      = olast_q;

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !q_ready_o) else $error("queue popped while busy");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wait_q) |-> $past(st_q) == S_DIV) else $error("waiting armed without timeout");
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_REGOUT |-> ri_q < count_q) else $error("register index past count");
endmodule

>>> rtl/modbus_rtu_read_regs_master.sv
// Top level of the Modbus RTU read-registers master.
// A start item with a register count of 1 to 32 gets its request CRC, then gives 8
// transmit items, one a cycle while the output is not stalled, then holds the back part
// for the timeout division (one quotient bit a cycle). Reply bytes and ticks reach the
// back part through the front queue; a good reply emits each register (store read), then
// the status. Reset clears control state at once; the register store needs no clearing.
module modbus_rtu_read_regs_master import mrrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from low: slave_addr[7:0], func_code[7:0], start_reg[15:0], reg_count[7:0],
  // rx_byte[7:0].
  input  logic [47:0] s_axis_tdata,
  // kind[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from low: tx_byte[7:0], reg_index[6:0], reg_value[15:0], status[2:0], pad.
  output logic [39:0] m_axis_tdata,
  // out_kind[1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  logic [15:0] turn_q;
  logic [19:0] baud_q;
  in_item_t    in_item, q_item;
  logic        q_valid, q_ready;
  logic [7:0]  tx_byte;
  logic [6:0]  reg_index;
  logic [15:0] reg_value;
  logic [2:0]  status;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q <= 16'd150;
      baud_q <= 20'd9600;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TURNAROUND: turn_q <= cfg_data_i[15:0];
        CFG_BAUD:       baud_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.kind       = s_axis_tuser;
  assign in_item.slave_addr = s_axis_tdata[7:0];
  assign in_item.func_code  = s_axis_tdata[15:8];
  assign in_item.start_reg  = s_axis_tdata[31:16];
  assign in_item.reg_count  = s_axis_tdata[39:32];
  assign in_item.rx_byte    = s_axis_tdata[47:40];

  mrrm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  mrrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .turnaround_i(turn_q),
    .baud_i      (baud_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .tx_byte_o   (tx_byte),
    .reg_index_o (reg_index),
    .reg_value_o (reg_value),
    .status_o    (status),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, status, reg_value, reg_index, tx_byte};
endmodule
